[src/vvf_pkg.sv]
// Shared types and constants for the voxel visible-face mask block.
`default_nettype none
package vvf_pkg;

  localparam int COORD_W      = 4;
  localparam int FACES        = 6;
  localparam int COUNT_W      = 3;
  localparam int STEP_W       = 3;
  localparam int GRID_EDGE_DF = 16;

  // Face bit positions in the mask
  localparam int FACE_XP = 0;
  localparam int FACE_XM = 1;
  localparam int FACE_YP = 2;
  localparam int FACE_YM = 3;
  localparam int FACE_ZP = 4;
  localparam int FACE_ZM = 5;

  // Step at which the last read word lands
  localparam logic [STEP_W-1:0] WRITE_LAST = 3'd1;
  localparam logic [STEP_W-1:0] QUERY_LAST = 3'd5;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef logic [COORD_W-1:0] coord_t;

  // What the evaluator sees of one item after its reads
  typedef struct packed {
    opcode_e          opcode;
    logic             in_grid;
    logic             solid_in;
    logic             here;
    logic [FACES-1:0] nbr_solid;
    logic [FACES-1:0] nbr_ok;
  } vvf_probe_t;

  typedef struct packed {
    logic               is_solid;
    logic [FACES-1:0]   face_mask;
    logic [COUNT_W-1:0] face_count;
  } vvf_result_t;

endpackage
`default_nettype wire

[src/vvf_if.sv]
// Handshake interfaces for the request and result words.
`default_nettype none
interface vvf_in_if
  import vvf_pkg::*;
();
  logic    valid;
  logic    ready;
  opcode_e opcode;
  coord_t  coord_x;
  coord_t  coord_y;
  coord_t  coord_z;
  logic    solid_in;

  modport source (output valid, opcode, coord_x, coord_y, coord_z, solid_in, input ready);
  modport sink   (input valid, opcode, coord_x, coord_y, coord_z, solid_in, output ready);
endinterface

interface vvf_out_if
  import vvf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               is_solid;
  logic [FACES-1:0]   face_mask;
  logic [COUNT_W-1:0] face_count;

  modport source (output valid, is_solid, face_mask, face_count, input ready);
  modport sink   (input valid, is_solid, face_mask, face_count, output ready);
endinterface
`default_nettype wire

[src/vvf_row_mem.sv]
// Occupancy row memory: one write port, one registered read port.
`default_nettype none
module vvf_row_mem #(
  parameter int Depth = 256,
  parameter int Width = 16,
  parameter int Aw    = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output      logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[src/vvf_face_eval.sv]
// Turns the gathered occupancy bits of one item into its result word.
`default_nettype none
module vvf_face_eval
  import vvf_pkg::*;
(
  input  vvf_probe_t  probe_i,
  output vvf_result_t result_o
);

  logic               query_hit;
  logic [FACES-1:0]   mask;
  logic [COUNT_W-1:0] count;

  assign query_hit = probe_i.in_grid && (probe_i.opcode == OP_QUERY) && probe_i.here;

  // on a query of a solid in-grid voxel, a face shows unless a neighbor inside the grid is solid; else no face
  assign mask = query_hit ? ~(probe_i.nbr_ok & probe_i.nbr_solid) : '0;

  always_comb begin
    count = '0;
    for (int i = 0; i < FACES; i++) begin
      count = count + COUNT_W'(mask[i]);
    end
  end

  always_comb begin
    result_o.face_mask  = mask;
    result_o.face_count = count;
    if (!probe_i.in_grid) begin
      result_o.is_solid = 1'b0;
    end else if (probe_i.opcode == OP_WRITE) begin
      result_o.is_solid = probe_i.solid_in;
    end else begin
      result_o.is_solid = probe_i.here;
    end
  end

endmodule
`default_nettype wire

[src/voxel_visible_face_mask.sv]
// Top level of the voxel visible-face mask block.
// The block keeps a GRID_EDGE^3 solid/empty grid in one row memory, one row
// per (x, y) holding all z bits, and serves one request word at a time: a
// write updates one voxel, a query returns the voxel's occupancy and its
// six-bit visible-face mask (bit0 +x, bit1 -x, bit2 +y, bit3 -y, bit4 +z,
// bit5 -z) with its bit count. Faces on the grid boundary always show;
// coordinates at or beyond GRID_EDGE give an all-zero result and a write
// there is dropped. After reset the block sweeps all GRID_EDGE^2 rows (256
// at the default edge) to all solid, one row per cycle, with in ready low.
// A write then does one row read and then a write-back; a query does five
// row reads on the single read port: own row, then the +x, -x, +y, -y rows.
// Results sit in an output register, so the next word is taken while a
// result waits.
`default_nettype none
module voxel_visible_face_mask
  import vvf_pkg::*;
#(
  parameter int GRID_EDGE = GRID_EDGE_DF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  vvf_in_if.sink   in_i,
  vvf_out_if.source out_o
);

  localparam int Rows  = GRID_EDGE * GRID_EDGE;
  localparam int RowAw = $clog2(Rows);
  localparam int ZW    = $clog2(GRID_EDGE);
  // coordinate math width: holds a 4-bit coordinate plus one and GRID_EDGE
  localparam int CmpW  = ($clog2(GRID_EDGE + 1) > COORD_W) ? $clog2(GRID_EDGE + 1) + 1
                                                           : COORD_W + 1;
  localparam logic [CmpW-1:0]  EdgeC    = CmpW'(GRID_EDGE);
  localparam logic [CmpW-1:0]  EdgeLast = CmpW'(GRID_EDGE - 1);
  localparam logic [RowAw-1:0] RowLast  = RowAw'(Rows - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [RowAw-1:0]   clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  vvf_result_t        out_q;

  // latched request word
  opcode_e            op_q;
  coord_t             x_q, y_q, z_q;
  logic               solid_q;

  // gathered occupancy
  logic [GRID_EDGE-1:0] row_q;
  logic [3:0]           nbr_q;   // +x, -x, +y, -y at this z

  logic [CmpW-1:0]  xc, yc, zc;
  logic             in_grid;
  logic [FACES-1:0] nbr_ok;
  logic [ZW-1:0]    zi, zpi, zmi;
  logic [RowAw-1:0] a_ctr, a_xp, a_xm, a_yp, a_ym, raddr;
  logic [GRID_EDGE-1:0] rdata, wrow, wdata;
  logic             mem_we;
  logic [RowAw-1:0] waddr;
  logic             out_free, last_step, in_acc;
  vvf_probe_t       probe;
  vvf_result_t      result;

  function automatic logic [RowAw-1:0] row_of(input logic [CmpW-1:0] x,
                                              input logic [CmpW-1:0] y);
    return RowAw'(RowAw'(x) * RowAw'(GRID_EDGE) + RowAw'(y));
  endfunction

  assign xc = CmpW'(x_q);
  assign yc = CmpW'(y_q);
  assign zc = CmpW'(z_q);

  assign in_grid = (xc < EdgeC) && (yc < EdgeC) && (zc < EdgeC);

  assign nbr_ok[FACE_XP] = xc < EdgeLast;
  assign nbr_ok[FACE_XM] = xc != '0;
  assign nbr_ok[FACE_YP] = yc < EdgeLast;
  assign nbr_ok[FACE_YM] = yc != '0;
  assign nbr_ok[FACE_ZP] = zc < EdgeLast;
  assign nbr_ok[FACE_ZM] = zc != '0;

  // neighbor rows fall back to the own row when outside the grid
  assign a_ctr = row_of(xc, yc);
  assign a_xp  = nbr_ok[FACE_XP] ? row_of(xc + CmpW'(1), yc) : a_ctr;
  assign a_xm  = nbr_ok[FACE_XM] ? row_of(xc - CmpW'(1), yc) : a_ctr;
  assign a_yp  = nbr_ok[FACE_YP] ? row_of(xc, yc + CmpW'(1)) : a_ctr;
  assign a_ym  = nbr_ok[FACE_YM] ? row_of(xc, yc - CmpW'(1)) : a_ctr;

  assign zi  = ZW'(zc);
  assign zpi = nbr_ok[FACE_ZP] ? ZW'(zc + CmpW'(1)) : zi;
  assign zmi = nbr_ok[FACE_ZM] ? ZW'(zc - CmpW'(1)) : zi;

  always_comb begin
    case (step_q)
      3'd1:    raddr = a_xp;
      3'd2:    raddr = a_xm;
      3'd3:    raddr = a_yp;
      3'd4:    raddr = a_ym;
      default: raddr = a_ctr;
    endcase
  end

  always_comb begin
    wrow     = row_q;
    wrow[zi] = solid_q;
  end

  vvf_row_mem #(
    .Depth (Rows),
    .Width (GRID_EDGE),
    .Aw    (RowAw)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    probe.opcode    = op_q;
    probe.in_grid   = in_grid;
    probe.solid_in  = solid_q;
    probe.here      = row_q[zi];
    probe.nbr_solid = {row_q[zmi], row_q[zpi], nbr_q[3], nbr_q[2], nbr_q[1], nbr_q[0]};
    probe.nbr_ok    = nbr_ok;
  end

  vvf_face_eval u_eval (
    .probe_i  (probe),
    .result_o (result)
  );

  assign out_free  = !out_valid_q || out_o.ready;
  assign last_step = (op_q == OP_QUERY) ? (step_q == QUERY_LAST) : (step_q == WRITE_LAST);
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    waddr       = a_ctr;
    wdata       = wrow;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_q;
        wdata  = '1;
        clr_d  = clr_q + RowAw'(1);
        if (clr_q == RowLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          step_d  = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        step_d = step_q + STEP_W'(1);
        if (last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          mem_we      = (op_q == OP_WRITE) && in_grid;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload: request latch, gathered bits, result word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= in_i.opcode;
      x_q     <= in_i.coord_x;
      y_q     <= in_i.coord_y;
      z_q     <= in_i.coord_z;
      solid_q <= in_i.solid_in;
    end
    if (state_q == ST_READ) begin
      case (step_q)
        3'd1:    row_q    <= rdata;
        3'd2:    nbr_q[0] <= rdata[zi];
        3'd3:    nbr_q[1] <= rdata[zi];
        3'd4:    nbr_q[2] <= rdata[zi];
        3'd5:    nbr_q[3] <= rdata[zi];
        default: ;
      endcase
    end
    if (state_q == ST_DONE && out_free) begin
      out_q <= result;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.is_solid   = out_q.is_solid;
  assign out_o.face_mask  = out_q.face_mask;
  assign out_o.face_count = out_q.face_count;

`ifndef SYNTHESIS
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.face_count == COUNT_W'($countones(out_q.face_mask)))
    else $error("face count does not match mask");

  a_mask_needs_solid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.face_mask != '0) |-> out_q.is_solid)
    else $error("visible faces on an empty voxel");

  a_no_write_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !mem_we)
    else $error("memory written while gathering a word");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("result overwritten before it was taken");
`endif

endmodule
`default_nettype wire

[sim/vvf_checker.sv]
// Checker for the voxel face mask block: predicts each result word and compares.
`timescale 1ns / 1ps
module vvf_checker
  import vvf_pkg::*;
#(
  parameter int GRID_EDGE = GRID_EDGE_DF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vvf_in_if         req_i,
  vvf_out_if        res_i,
  output int        fail_cnt_o,
  output int        pending_o,
  output int        lit_cnt_o
);

  localparam int CELLS = GRID_EDGE * GRID_EDGE * GRID_EDGE;

  logic        occ_q [CELLS];
  vvf_result_t answer_q [$];
  int          fails;
  int          lit;

  // Neighbor outside the grid reads as empty
  function automatic logic solid_near(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= GRID_EDGE || y >= GRID_EDGE || z >= GRID_EDGE)
      return 1'b0;
    return occ_q[(x * GRID_EDGE + y) * GRID_EDGE + z];
  endfunction

  // Applies one request word to the grid copy and returns its answer
  function automatic vvf_result_t voxel_answer(opcode_e op, coord_t cx, coord_t cy, coord_t cz,
                                               logic solid);
    vvf_result_t ans;
    int          x;
    int          y;
    int          z;
    int          idx;
    ans = '0;
    x   = int'(cx);
    y   = int'(cy);
    z   = int'(cz);
    idx = (x * GRID_EDGE + y) * GRID_EDGE + z;
    if (x < GRID_EDGE && y < GRID_EDGE && z < GRID_EDGE) begin
      if (op == OP_WRITE) begin
        occ_q[idx]   = solid;
        ans.is_solid = solid;
      end else if (occ_q[idx]) begin
        ans.is_solid           = 1'b1;
        ans.face_mask[FACE_XP] = !solid_near(x + 1, y, z);
        ans.face_mask[FACE_XM] = !solid_near(x - 1, y, z);
        ans.face_mask[FACE_YP] = !solid_near(x, y + 1, z);
        ans.face_mask[FACE_YM] = !solid_near(x, y - 1, z);
        ans.face_mask[FACE_ZP] = !solid_near(x, y, z + 1);
        ans.face_mask[FACE_ZM] = !solid_near(x, y, z - 1);
      end
    end
    ans.face_count = COUNT_W'($countones(ans.face_mask));
    return ans;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    vvf_result_t want;
    if (!rst_ni) begin
      foreach (occ_q[i]) occ_q[i] = 1'b1;
      answer_q.delete();
      fails = 0;
      lit   = 0;
    end else begin
      // Pop before push: a word taken this edge cannot answer at this edge
      if (res_i.valid && res_i.ready) begin
        if (answer_q.size() == 0) begin
          $error("result word with no request outstanding");
          fails++;
        end else begin
          want = answer_q.pop_front();
          check_field("is_solid", 8'(want.is_solid), 8'(res_i.is_solid));
          check_field("face_mask", 8'(want.face_mask), 8'(res_i.face_mask));
          check_field("face_count", 8'(want.face_count), 8'(res_i.face_count));
          if (want.face_mask != '0) lit++;
        end
      end
      if (req_i.valid && req_i.ready)
        answer_q.push_back(voxel_answer(req_i.opcode, req_i.coord_x, req_i.coord_y,
                                        req_i.coord_z, req_i.solid_in));
    end
    fail_cnt_o <= fails;
    pending_o  <= answer_q.size();
    lit_cnt_o  <= lit;
  end

endmodule

[sim/voxel_visible_face_mask_test.sv]
// Testbench top for the voxel face mask block: stimulus, output pacing and verdict.
`timescale 1ns / 1ps
module voxel_visible_face_mask_test
  import vvf_pkg::*;
();

  localparam int EDGE           = GRID_EDGE_DF;
  localparam int ITEMS          = 1900;
  // One long output hold-off, starting once this many words went in
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 300;
  // Input side waits for an empty pipe at this word count
  localparam int DRAIN_AT       = 1000;
  // Window of words with no idling on either side
  localparam int CALM_LO        = 1300;
  localparam int CALM_HI        = 1500;
  // Longer than the reset sweep, a query or the hold-off: this is
  // several times the longest quiet stretch of a correct run
  localparam int WATCHDOG_LIMIT = 3000;
  // Tail wait for stray words after the drain
  localparam int TAIL_CYCLES    = 32;
  localparam int CLUSTER_LEN    = 24;

  logic clk_i = 1'b0;
  logic rst_ni;

  int fail_cnt;
  int pending;
  int lit_cnt;
  int sent_cnt    = 0;
  int writes_sent = 0;
  int queries_sent = 0;

  vvf_in_if  req_if ();
  vvf_out_if res_if ();

  always #2 clk_i = ~clk_i;

  voxel_visible_face_mask #(
    .GRID_EDGE(EDGE)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  vvf_checker #(
    .GRID_EDGE(EDGE)
  ) u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .res_i     (res_if),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending),
    .lit_cnt_o (lit_cnt)
  );

  // Idle length for either side: mostly none or short, now and then long.
  // Inside the calm window both sides run flat out.
  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(0, 99);
    if (sent_cnt >= CALM_LO && sent_cnt < CALM_HI) return 0;
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Focus coordinate for a cluster; grid faces get a good share
  function automatic int pick_focus();
    if ($urandom_range(0, 9) < 3) return $urandom_range(0, 1) ? EDGE - 1 : 0;
    return $urandom_range(0, EDGE - 1);
  endfunction

  // Offers one word until taken, then idles a random while. Coordinates
  // wrap to the 4-bit field, so focus +/- 1 stays legal.
  task automatic send_word(opcode_e op, int x, int y, int z, logic solid);
    int idle;
    req_if.valid    <= 1'b1;
    req_if.opcode   <= op;
    req_if.coord_x  <= coord_t'(x);
    req_if.coord_y  <= coord_t'(y);
    req_if.coord_z  <= coord_t'(z);
    req_if.solid_in <= solid;
    do @(posedge clk_i); while (!req_if.ready);
    sent_cnt++;
    if (op == OP_WRITE) writes_sent++;
    else queries_sent++;
    idle = pick_idle();
    if (idle > 0) begin
      req_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
  endtask

  // Drops valid and waits until every expected word has come back.
  // pending is registered, so the task waits for an edge before its first look.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Output side pacing, with one long hold-off while the input keeps
  // offering words, so the output register fills and in ready drops.
  initial begin
    int idle;
    bit held;
    held = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (!held && sent_cnt >= HOLD_AT) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        idle = pick_idle();
        if (idle == 0) begin
          res_if.ready <= 1'b1;
          @(posedge clk_i);
        end else begin
          res_if.ready <= 1'b0;
          repeat (idle) @(posedge clk_i);
        end
      end
    end
  end

  // Watchdog: too many cycles with no word moving on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word moved for %0d cycles, %0d outstanding",
             WATCHDOG_LIMIT, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int fx;
    int fy;
    int fz;
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.opcode   <= OP_WRITE;
    req_if.coord_x  <= '0;
    req_if.coord_y  <= '0;
    req_if.coord_z  <= '0;
    req_if.solid_in <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Grid starts all solid, so only grid faces show.
    send_word(OP_QUERY, 0, 0, 0, 1'b0);                // low corner: -x -y -z
    send_word(OP_QUERY, EDGE - 1, EDGE - 1, EDGE - 1, 1'b1); // high corner: +x +y +z
    send_word(OP_QUERY, 7, 8, 9, 1'b0);                // buried voxel: no faces
    send_word(OP_QUERY, EDGE - 1, 0, 7, 1'b0);         // edge voxel
    // Hollow out one voxel and look at it from all six sides
    send_word(OP_WRITE, 7, 8, 9, 1'b0);
    send_word(OP_QUERY, 7, 8, 9, 1'b1);                // empty: all zero
    send_word(OP_QUERY, 8, 8, 9, 1'b0);
    send_word(OP_QUERY, 6, 8, 9, 1'b0);
    send_word(OP_QUERY, 7, 9, 9, 1'b0);
    send_word(OP_QUERY, 7, 7, 9, 1'b0);
    send_word(OP_QUERY, 7, 8, 10, 1'b0);
    send_word(OP_QUERY, 7, 8, 8, 1'b0);
    send_word(OP_WRITE, 7, 8, 9, 1'b1);                // fill back in
    send_word(OP_QUERY, 8, 8, 9, 1'b0);
    send_word(OP_WRITE, 0, 0, 0, 1'b1);                // rewrite a solid voxel
    // Corner plus an empty inner neighbor
    send_word(OP_WRITE, 1, 0, 0, 1'b0);
    send_word(OP_QUERY, 0, 0, 0, 1'b1);
    // Isolated voxel: all six faces
    send_word(OP_WRITE, 4, 12, 5, 1'b0);
    send_word(OP_WRITE, 2, 12, 5, 1'b0);
    send_word(OP_WRITE, 3, 13, 5, 1'b0);
    send_word(OP_WRITE, 3, 11, 5, 1'b0);
    send_word(OP_WRITE, 3, 12, 6, 1'b0);
    send_word(OP_WRITE, 3, 12, 4, 1'b0);
    send_word(OP_QUERY, 3, 12, 5, 1'b0);

    // Random part: clusters of words around a focus voxel so writes and
    // queries hit each other's neighborhoods, plus some scattered words.
    // Writes lean toward empty to carve holes into the solid grid.
    while (sent_cnt < ITEMS) begin
      fx = pick_focus();
      fy = pick_focus();
      fz = pick_focus();
      repeat (CLUSTER_LEN) begin
        if ($urandom_range(0, 99) < 15)
          send_word(opcode_e'($urandom_range(0, 1)), $urandom_range(0, 15),
                    $urandom_range(0, 15), $urandom_range(0, 15),
                    1'($urandom_range(0, 1)));
        else
          send_word(($urandom_range(0, 99) < 45) ? OP_WRITE : OP_QUERY,
                    fx + int'($urandom_range(0, 2)) - 1,
                    fy + int'($urandom_range(0, 2)) - 1,
                    fz + int'($urandom_range(0, 2)) - 1,
                    $urandom_range(0, 99) < 40);
        if (sent_cnt == DRAIN_AT) drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d writes and %0d queries, %0d answers with visible faces.",
             writes_sent, queries_sent, lit_cnt);
    $display("Output held off %0d cycles under load; input drained to empty mid-run.",
             HOLD_CYCLES);
    if (fail_cnt == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
